// File: rtl/core/pls_pkg.sv
package pls_pkg;

  // default list capacity in entries
  localparam int PLS_CAPACITY = 32;

  localparam int ELEM_W = 8;
  localparam int POS_W  = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_PRINT  = 2'd3
  } pls_op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } pls_status_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;     // capture the accepted transaction
    logic exec_op;      // perform add, delete, get or empty print and load a result
    logic print_start;  // clear the print index
    logic print_emit;   // load the entry under the print index as a result
  } pls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;     // result register can take a new result this cycle
    logic is_print;     // held command is a print
    logic list_empty;   // no entries stored
    logic print_last;   // print index points at the final entry
  } pls_stat_t;

endpackage

// File: rtl/core/positional_list_store_top.sv
// channel | dir | tdata (lsb first)                    | tuser          | tlast
// in_     | in  | position[7:0], new_element[15:8]     | command[1:0]   | -
// out_    | out | status[1:0], element[9:2], zero fill | element_valid  | last
//
// one transaction at a time: accept, then add, delete or get in the execute state
// (shifting the whole register file at once) once the result register is free
// a print takes the accept state, a start step, then emits each stored entry in
// turn; a print of an empty list runs like any other command
// in_tready is high while the controller idles, even with a result still held
// a stalled out_ channel holds the result register and the controller waits
// synchronous active-low reset empties the list; stored entries keep stale data
module positional_list_store_top
  import pls_pkg::*;
#(
  parameter int CAPACITY = PLS_CAPACITY
)
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // position[7:0], new_element[15:8]
  input  logic [1:0]  in_tuser,   // command[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[1:0], element[9:2], zero[15:10]
  output logic [0:0]  out_tuser,  // element_valid
  output logic        out_tlast
);

  pls_cmd_t  cmd;
  pls_stat_t stat;

  logic [1:0]        out_status;
  logic [ELEM_W-1:0] out_element;
  logic              out_element_valid;

  // sequencing of each command
  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // list registers, count, print index and result register
  pls_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .command           (in_tuser),
    .position          (in_tdata[7:0]),
    .new_element       (in_tdata[15:8]),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_status        (out_status),
    .out_element       (out_element),
    .out_element_valid (out_element_valid),
    .out_last          (out_tlast)
  );

  assign out_tdata = {6'd0, out_element, out_status};
  assign out_tuser = out_element_valid;

  // no second transaction is taken straight after one is accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a command is in progress");

  // a loaded result is always presented
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec_op || cmd.print_emit) |=> out_tvalid)
    else $error("result loaded but not presented");

  // controller issues at most one command per cycle
  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch_in, cmd.exec_op, cmd.print_start, cmd.print_emit}))
    else $error("overlapping datapath commands");

  // a full-list result carries no element and ends its command
  a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == ST_FULL) |-> (out_tlast && !out_tuser[0]))
    else $error("malformed list-full result");

endmodule

// File: rtl/core/pls_ctrl.sv
module pls_ctrl
  import pls_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  pls_stat_t stat,
  output pls_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PRINT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_print && !stat.list_empty) begin
          cmd.print_start = 1'b1;
          state_nxt       = S_PRINT;
        end else if (stat.out_free) begin
          cmd.exec_op = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_PRINT: begin
        if (stat.out_free) begin
          cmd.print_emit = 1'b1;
          if (stat.print_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/pls_dp.sv
module pls_dp
  import pls_pkg::*;
#(
  parameter int CAPACITY = PLS_CAPACITY
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  pls_cmd_t          cmd,
  output pls_stat_t         stat,
  input  logic [1:0]        command,
  input  logic [POS_W-1:0]  position,
  input  logic [ELEM_W-1:0] new_element,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [ELEM_W-1:0] out_element,
  output logic              out_element_valid,
  output logic              out_last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = POS_W + 1;

  // held transaction
  pls_op_t           op_r;
  logic [POS_W-1:0]  pos_r;
  logic [ELEM_W-1:0] nel_r;

  logic [ELEM_W-1:0] store_r   [CAPACITY];
  logic [ELEM_W-1:0] store_nxt [CAPACITY];
  logic [ELEM_W-1:0] below_w   [CAPACITY];
  logic [ELEM_W-1:0] above_w   [CAPACITY];

  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [ELEM_W-1:0] out_element_r, out_element_nxt;
  logic              out_evalid_r, out_evalid_nxt;
  logic              out_last_r, out_last_nxt;
  logic              load_out;

  logic [PW-1:0] pos_w, n_w;
  logic          pos_zero, add_bad, del_bad, full;
  logic [IW-1:0] rd_addr;
  logic [ELEM_W-1:0] rd_data;
  logic          print_last;

  // neighbour taps for the shift
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_tap
    if (gi == 0) begin : g_lo
      assign below_w[gi] = store_r[gi];
    end else begin : g_mid_lo
      assign below_w[gi] = store_r[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_hi
      assign above_w[gi] = store_r[gi];
    end else begin : g_mid_hi
      assign above_w[gi] = store_r[gi+1];
    end
  end

  assign pos_w    = PW'(pos_r);
  assign n_w      = PW'(count_r);
  assign pos_zero = (pos_r == '0);
  assign add_bad  = pos_zero || (pos_w > n_w + PW'(1));
  assign del_bad  = pos_zero || (pos_w > n_w);
  assign full     = (count_r == CW'(CAPACITY));

  assign rd_addr    = cmd.print_emit ? idx_r : IW'(pos_r - POS_W'(1));
  assign rd_data    = store_r[rd_addr];
  assign print_last = ((CW'(idx_r) + CW'(1)) == count_r);

  assign load_out = cmd.exec_op || cmd.print_emit;

  always_comb begin
    store_nxt       = store_r;
    count_nxt       = count_r;
    out_status_nxt  = ST_OK;
    out_element_nxt = '0;
    out_evalid_nxt  = 1'b0;
    out_last_nxt    = 1'b1;
    if (cmd.print_emit) begin
      out_element_nxt = rd_data;
      out_evalid_nxt  = 1'b1;
      out_last_nxt    = print_last;
    end else if (cmd.exec_op) begin
      case (op_r)
        OP_ADD: begin
          if (add_bad) begin
            out_status_nxt = ST_BADPOS;
          end else if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (PW'(i) + PW'(1) == pos_w) begin
                store_nxt[i] = nel_r;
              end else if (PW'(i) >= pos_w && PW'(i) <= n_w) begin
                store_nxt[i] = below_w[i];
              end
            end
            count_nxt = count_r + CW'(1);
          end
        end
        OP_DELETE: begin
          if (del_bad) begin
            out_status_nxt = ST_BADPOS;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (PW'(i) + PW'(1) >= pos_w && PW'(i) + PW'(1) < n_w) begin
                store_nxt[i] = above_w[i];
              end
            end
            count_nxt = count_r - CW'(1);
          end
        end
        OP_GET: begin
          if (del_bad) begin
            out_status_nxt = ST_BADPOS;
          end else begin
            out_element_nxt = rd_data;
            out_evalid_nxt  = 1'b1;
          end
        end
        default: ;  // print of an empty list: one bare ok result
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= pls_op_t'(command);
      pos_r <= position;
      nel_r <= new_element;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      store_r[i] <= store_nxt[i];
    end
    if (cmd.print_start) begin
      idx_r <= '0;
    end else if (cmd.print_emit) begin
      idx_r <= idx_r + IW'(1);
    end
    if (load_out) begin
      out_status_r  <= out_status_nxt;
      out_element_r <= out_element_nxt;
      out_evalid_r  <= out_evalid_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.is_print   = (op_r == OP_PRINT);
  assign stat.list_empty = (count_r == '0);
  assign stat.print_last = print_last;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element       = out_element_r;
  assign out_element_valid = out_evalid_r;
  assign out_last          = out_last_r;

endmodule

// File: dv/positional_list_store_checker.sv
`timescale 1ns / 100ps

module positional_list_store_checker
  import pls_pkg::*;
#(
  parameter int CAPACITY = PLS_CAPACITY
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // position[7:0], new_element[15:8]
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // status[1:0], element[9:2], zero[15:10]
  input  logic [0:0]  out_tuser,  // element_valid
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          results_pending
);

  typedef struct {
    pls_status_t status;
    logic [7:0]  element;
    logic        elem_valid;
    logic        last;
  } list_result_t;

  list_result_t expected_results[$];

  // shadow copy of the stored list
  logic [7:0]  shadow_list [CAPACITY];
  int          shadow_len;

  function automatic void push_result(pls_status_t st, logic [7:0] el, logic v, logic l);
    list_result_t r;
    r.status     = st;
    r.element    = el;
    r.elem_valid = v;
    r.last       = l;
    expected_results.push_back(r);
  endfunction

  function automatic void apply_command(pls_op_t op, logic [7:0] pos, logic [7:0] el);
    int p;
    p = int'(pos);
    case (op)
      OP_ADD: begin
        if (p == 0 || p > shadow_len + 1) begin
          push_result(ST_BADPOS, 8'h00, 1'b0, 1'b1);
        end else if (shadow_len >= CAPACITY) begin
          push_result(ST_FULL, 8'h00, 1'b0, 1'b1);
        end else begin
          for (int i = shadow_len; i > p - 1; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[p - 1] = el;
          shadow_len++;
          push_result(ST_OK, 8'h00, 1'b0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (p == 0 || p > shadow_len) begin
          push_result(ST_BADPOS, 8'h00, 1'b0, 1'b1);
        end else begin
          for (int i = p - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
          push_result(ST_OK, 8'h00, 1'b0, 1'b1);
        end
      end
      OP_GET: begin
        if (p == 0 || p > shadow_len) begin
          push_result(ST_BADPOS, 8'h00, 1'b0, 1'b1);
        end else begin
          push_result(ST_OK, shadow_list[p - 1], 1'b1, 1'b1);
        end
      end
      default: begin
        // print: an empty list still gives one closing result
        if (shadow_len == 0) begin
          push_result(ST_OK, 8'h00, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++)
            push_result(ST_OK, shadow_list[i], 1'b1, (i == shadow_len - 1));
        end
      end
    endcase
  endfunction

  function automatic void compare_result();
    list_result_t exp_r;
    if (expected_results.size() == 0) begin
      $error("unexpected result: tdata %h tuser %b tlast %b", out_tdata, out_tuser, out_tlast);
      mismatch_count++;
    end else begin
      exp_r = expected_results.pop_front();
      if (out_tdata[1:0] !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, out_tdata[1:0]);
        mismatch_count++;
      end
      if (out_tdata[9:2] !== exp_r.element) begin
        $error("element: expected %h, actual %h", exp_r.element, out_tdata[9:2]);
        mismatch_count++;
      end
      if (out_tuser[0] !== exp_r.elem_valid) begin
        $error("element_valid: expected %b, actual %b", exp_r.elem_valid, out_tuser[0]);
        mismatch_count++;
      end
      if (out_tlast !== exp_r.last) begin
        $error("last: expected %b, actual %b", exp_r.last, out_tlast);
        mismatch_count++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      shadow_len     = 0;
      mismatch_count = 0;
    end else begin
      // a result leaves a register, so it never belongs to a command taken at this edge
      if (out_tvalid && out_tready) compare_result();
      if (in_tvalid && in_tready)
        apply_command(pls_op_t'(in_tuser), in_tdata[7:0], in_tdata[15:8]);
    end
    results_pending = expected_results.size();
  end

endmodule

// File: dv/positional_list_store_top_tb.sv
`timescale 1ns / 100ps

module positional_list_store_top_tb;
  import pls_pkg::*;

  localparam int CAPACITY       = PLS_CAPACITY;
  localparam int RANDOM_ITEMS   = 480;
  localparam int WATCHDOG_LIMIT = 2000;

  // command mix of a random phase
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED
  } cmd_mix_t;

  // receiver behaviour of a stretch
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_THIRDS,
    RX_BURSTY
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;   // position[7:0], new_element[15:8]
  logic [1:0]  in_tuser = 2'b00;      // command[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;             // status[1:0], element[9:2], zero[15:10]
  logic [0:0]  out_tuser;             // element_valid
  logic        out_tlast;

  int mismatch_count;
  int results_pending;

  // sender bookkeeping: burst length left and a count-only view of the list
  int burst_left = 0;
  int list_len   = 0;

  // receiver pattern state
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_left = 0;
  int       rx_tick = 0;

  int idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  positional_list_store_top #(
    .CAPACITY (CAPACITY)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  positional_list_store_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // receiver: stretches of always-ready, coin flips, a one-in-three beat
  // and long stalls, so back-pressure lands on every step of a print
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(5, 60);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS: out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_THIRDS: out_tready <= (rx_tick % 3 == 0);
      default:   out_tready <= (rx_tick % 16 < 2);
    endcase
  end

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // offer one command and hold it until the block takes it; bursts of
  // back-to-back transactions are broken up by random gaps
  task automatic send_command(input pls_op_t op, input logic [7:0] pos,
                              input logic [7:0] elem);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {elem, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    // keep the count only, to steer positions into range
    case (op)
      OP_ADD:    if (pos != 0 && pos <= list_len + 1 && list_len < CAPACITY) list_len++;
      OP_DELETE: if (pos != 0 && pos <= list_len) list_len--;
      default: ;
    endcase
  endtask

  // mostly a legal position up to hi, sometimes an edge or anything at all
  function automatic logic [7:0] pick_position(int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 85 && hi >= 1) return 8'($urandom_range(1, hi));
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'(hi + 1);
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    cmd_mix_t mix;
    int       mix_left;
    int       r;
    pls_op_t  op;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, bad positions, edges of the data, space character
    send_command(OP_PRINT,  8'd1,   8'h00);  // empty print gives one result
    send_command(OP_GET,    8'd1,   8'h00);
    send_command(OP_DELETE, 8'd1,   8'h00);
    send_command(OP_ADD,    8'd0,   8'h55);  // position zero
    send_command(OP_ADD,    8'd2,   8'h55);  // one past count+1
    send_command(OP_ADD,    8'd1,   8'h00);
    send_command(OP_ADD,    8'd2,   8'hFF);
    send_command(OP_ADD,    8'd1,   8'h20);  // space stored as a normal byte
    send_command(OP_ADD,    8'd255, 8'hAA);
    send_command(OP_ADD,    8'd4,   8'h80);  // append at count+1
    send_command(OP_GET,    8'd0,   8'h00);
    send_command(OP_GET,    8'd1,   8'h00);
    send_command(OP_GET,    8'd4,   8'h00);
    send_command(OP_GET,    8'd5,   8'h00);
    send_command(OP_GET,    8'd255, 8'hFF);
    send_command(OP_DELETE, 8'd0,   8'h00);
    send_command(OP_DELETE, 8'd5,   8'h00);
    send_command(OP_PRINT,  8'd0,   8'h00);
    send_command(OP_DELETE, 8'd2,   8'h00);  // middle entry
    send_command(OP_DELETE, 8'd3,   8'h00);  // final entry
    send_command(OP_PRINT,  8'hFF,  8'hFF);
    send_command(OP_GET,    8'd1,   8'h00);

    // random: phases that grow, shrink or churn the list; the first one
    // is long and add-heavy so the list reaches full early on
    mix      = MIX_GROW;
    mix_left = 100;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (mix_left == 0) begin
        mix      = cmd_mix_t'($urandom_range(0, 2));
        mix_left = $urandom_range(15, 60);
      end
      mix_left--;
      r = $urandom_range(0, 99);
      case (mix)
        MIX_GROW:   op = (r < 65) ? OP_ADD : (r < 75) ? OP_DELETE : (r < 95) ? OP_GET : OP_PRINT;
        MIX_SHRINK: op = (r < 20) ? OP_ADD : (r < 70) ? OP_DELETE : (r < 95) ? OP_GET : OP_PRINT;
        default:    op = (r < 35) ? OP_ADD : (r < 60) ? OP_DELETE : (r < 90) ? OP_GET : OP_PRINT;
      endcase
      if ($urandom_range(0, 99) < 6) begin
        // noise: anything at all
        send_command(pls_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end else if (op == OP_ADD) begin
        send_command(op, pick_position(list_len + 1), 8'($urandom_range(0, 255)));
      end else begin
        send_command(op, pick_position(list_len), 8'($urandom_range(0, 255)));
      end
    end
    in_tvalid <= 1'b0;

    // let the checker see the final transaction before reading its queue
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pls_pkg.sv
rtl/core/pls_ctrl.sv
rtl/core/pls_dp.sv
rtl/core/positional_list_store_top.sv
dv/positional_list_store_checker.sv
dv/positional_list_store_top_tb.sv
